@@ rtl/core/kst_pkg.sv @@
// Shared types, constants and helpers of the keyed slot table upsert unit.
// Used by kst_seq, the top level and the port checker; depends on nothing.
`default_nettype none

package kst_pkg;

   // table geometry
   localparam int SLOT_COUNT = 100;
   localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int IDX_W      = 7;
   localparam int DATA_W     = 32;
   localparam int REC_W      = 4 * DATA_W;

   localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(SLOT_COUNT - 1);
   localparam logic [IDX_W:0]    SLOT_LIMIT = (IDX_W + 1)'(SLOT_COUNT);

   // request opcodes
   localparam logic [1:0] OP_PLACE  = 2'd0;
   localparam logic [1:0] OP_UPSERT = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   // response status codes
   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_NOT_LIVE = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_RANGE    = 2'd3;

   typedef struct packed {
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] rating_a;
      logic [DATA_W-1:0] rating_b;
      logic [DATA_W-1:0] flags;
   } rec_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      rec_type           rec;
   } wr_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
   } rd_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [IDX_W-1:0] used;
      rec_type          rec;
   } res_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_RD_WAIT,
      S_SCAN,
      S_FIN
   } state_type;

   // live: flag bit 0 set and key above zero as a signed word
   function automatic logic is_live(rec_type r);
      return r.flags[0] && !r.key[DATA_W-1] && (r.key != '0);
   endfunction

   function automatic logic in_range(logic [IDX_W-1:0] idx);
      return {1'b0, idx} < SLOT_LIMIT;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/keyed_slot_table_upsert_unit.sv @@
// A place passes S_DISPATCH and S_FIN, a read S_DISPATCH, S_RD_WAIT and S_FIN,
// an upsert S_DISPATCH, S_SCAN and S_FIN, before the response register; the upsert
// scan reads one slot per cycle through the record RAM's single read port.
// Throughput: one request at a time; req_ready is high only while idle.
// Reset: synchronous, active high; clears the per-slot valid bits (every slot
// reads as an all-zero record) and the control state; no clearing pass.
// Top level of the keyed slot table upsert unit; depends on kst_pkg,
// kst_ram and kst_seq.
`default_nettype none

module keyed_slot_table_upsert_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_opcode,
   input  wire logic [6:0]         req_slot_index,
   input  wire logic signed [31:0] req_profile_key,
   input  wire logic [31:0]        req_rating_a_bits,
   input  wire logic [31:0]        req_rating_b_bits,
   input  wire logic [31:0]        req_record_flags,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [1:0]              rsp_status,
   output logic [6:0]              rsp_used_slot,
   output logic signed [31:0]      rsp_out_key,
   output logic [31:0]             rsp_out_rating_a,
   output logic [31:0]             rsp_out_rating_b,
   output logic [31:0]             rsp_out_flags
);

   kst_pkg::rec_type  req_rec;
   kst_pkg::rec_type  rd_rec;
   kst_pkg::wr_type   wr;
   kst_pkg::rd_type   rd;
   kst_pkg::res_type  res;
   logic              res_load;
   logic              out_free;
   logic [kst_pkg::REC_W-1:0] ram_q;

   logic [kst_pkg::SLOT_COUNT-1:0] vld_ff;
   logic                           rd_vld_ff;

   logic             rsp_valid_ff;
   kst_pkg::res_type rsp_res_ff;

   assign req_rec.key      = $unsigned(req_profile_key);
   assign req_rec.rating_a = req_rating_a_bits;
   assign req_rec.rating_b = req_rating_b_bits;
   assign req_rec.flags    = req_record_flags;

   // record storage
   kst_ram #(
      .WIDTH (kst_pkg::REC_W),
      .DEPTH (kst_pkg::SLOT_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.rec),
      .rd_en   (rd.en),
      .rd_addr (rd.addr),
      .rd_data (ram_q)
   );

   // per-slot valid bits; an unwritten slot reads as all zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr.en) begin
         vld_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_vld_ff <= vld_ff[rd.addr];
      end
   end

   assign rd_rec = rd_vld_ff ? kst_pkg::rec_type'(ram_q) : '0;

   // sequencer
   kst_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_opcode),
      .req_idx   (req_slot_index),
      .req_rec   (req_rec),
      .rd_rec    (rd_rec),
      .out_free  (out_free),
      .wr        (wr),
      .rd        (rd),
      .res_load  (res_load),
      .res       (res)
   );

   // response output register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_res_ff <= res;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_res_ff.status;
   assign rsp_used_slot    = rsp_res_ff.used;
   assign rsp_out_key      = $signed(rsp_res_ff.rec.key);
   assign rsp_out_rating_a = rsp_res_ff.rec.rating_a;
   assign rsp_out_rating_b = rsp_res_ff.rec.rating_b;
   assign rsp_out_flags    = rsp_res_ff.rec.flags;

endmodule

`default_nettype wire

@@ rtl/core/kst_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module kst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/kst_seq.sv @@
// Sequencer and shared key compare unit of the keyed slot table upsert unit.
// Decodes a request, scans the table one slot a cycle, builds the response.
// Depends on kst_pkg.
`default_nettype none

module kst_seq (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire logic [1:0]                req_op,
   input  wire logic [kst_pkg::IDX_W-1:0] req_idx,
   input  wire kst_pkg::rec_type          req_rec,
   input  wire kst_pkg::rec_type          rd_rec,
   input  wire logic                      out_free,
   output kst_pkg::wr_type                wr,
   output kst_pkg::rd_type                rd,
   output logic                           res_load,
   output kst_pkg::res_type               res
);

   kst_pkg::state_type state_ff, state_in;

   // latched request
   logic [1:0]                op_ff;
   logic [kst_pkg::IDX_W-1:0] idx_ff;
   kst_pkg::rec_type          rec_ff;

   // scan bookkeeping
   logic [kst_pkg::SLOT_W-1:0] scan_ff, scan_in;
   logic [kst_pkg::SLOT_W-1:0] cmp_ff, cmp_in;
   logic                       pend_ff, pend_in;
   logic                       free_seen_ff, free_seen_in;
   logic [kst_pkg::SLOT_W-1:0] free_slot_ff, free_slot_in;

   kst_pkg::res_type res_ff, res_in;

   logic                       idx_ok;
   logic                       new_live;
   logic [kst_pkg::SLOT_W-1:0] idx_slot;
   logic                       scan_hit;
   logic                       scan_free;
   logic                       scan_last;

   assign idx_ok    = kst_pkg::in_range(idx_ff);
   assign new_live  = kst_pkg::is_live(rec_ff);
   assign idx_slot  = idx_ff[kst_pkg::SLOT_W-1:0];

   // shared compare unit: one stored slot against the request key
   assign scan_hit  = rd_rec.flags[0] && (rd_rec.key == rec_ff.key);
   assign scan_free = !rd_rec.flags[0];
   assign scan_last = (cmp_ff == kst_pkg::LAST_SLOT);

   assign req_ready = (state_ff == kst_pkg::S_IDLE);
   assign res       = res_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kst_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = kst_pkg::S_DISPATCH;
            end
         end
         kst_pkg::S_DISPATCH: begin
            if (op_ff == kst_pkg::OP_UPSERT && new_live) begin
               state_in = kst_pkg::S_SCAN;
            end else if (op_ff == kst_pkg::OP_READ && idx_ok) begin
               state_in = kst_pkg::S_RD_WAIT;
            end else begin
               state_in = kst_pkg::S_FIN;
            end
         end
         kst_pkg::S_RD_WAIT: begin
            state_in = kst_pkg::S_FIN;
         end
         kst_pkg::S_SCAN: begin
            if (pend_ff && (scan_hit || scan_last)) begin
               state_in = kst_pkg::S_FIN;
            end
         end
         kst_pkg::S_FIN: begin
            if (out_free) begin
               state_in = kst_pkg::S_IDLE;
            end
         end
         default: state_in = kst_pkg::S_IDLE;
      endcase
   end

   // datapath controls and response build
   always_comb begin
      wr           = '0;
      rd           = '0;
      res_load     = 1'b0;
      res_in       = res_ff;
      scan_in      = scan_ff;
      cmp_in       = cmp_ff;
      pend_in      = pend_ff;
      free_seen_in = free_seen_ff;
      free_slot_in = free_slot_ff;
      unique case (state_ff)
         kst_pkg::S_IDLE: begin
            res_in        = '0;
            res_in.status = kst_pkg::ST_NOT_LIVE;
            scan_in       = '0;
            pend_in       = 1'b0;
            free_seen_in  = 1'b0;
         end
         kst_pkg::S_DISPATCH: begin
            case (op_ff)
               kst_pkg::OP_PLACE: begin
                  if (!idx_ok) begin
                     res_in.status = kst_pkg::ST_RANGE;
                  end else if (new_live) begin
                     wr.en         = 1'b1;
                     wr.addr       = idx_slot;
                     wr.rec        = rec_ff;
                     res_in.status = kst_pkg::ST_DONE;
                     res_in.used   = idx_ff;
                  end
               end
               kst_pkg::OP_READ: begin
                  if (!idx_ok) begin
                     res_in.status = kst_pkg::ST_RANGE;
                  end else begin
                     rd.en   = 1'b1;
                     rd.addr = idx_slot;
                  end
               end
               default: ;
            endcase
         end
         kst_pkg::S_RD_WAIT: begin
            res_in.used = idx_ff;
            if (kst_pkg::is_live(rd_rec)) begin
               res_in.status = kst_pkg::ST_DONE;
               res_in.rec    = rd_rec;
            end
         end
         kst_pkg::S_SCAN: begin
            // issue one read a cycle, compare the one issued last cycle
            rd.en   = 1'b1;
            rd.addr = scan_ff;
            if (scan_ff != kst_pkg::LAST_SLOT) begin
               scan_in = scan_ff + 1'b1;
            end
            cmp_in  = scan_ff;
            pend_in = 1'b1;
            if (pend_ff) begin
               if (scan_hit) begin
                  wr.en         = 1'b1;
                  wr.addr       = cmp_ff;
                  wr.rec        = rec_ff;
                  res_in.status = kst_pkg::ST_DONE;
                  res_in.used   = kst_pkg::IDX_W'(cmp_ff);
               end else if (scan_last) begin
                  if (free_seen_ff) begin
                     wr.en         = 1'b1;
                     wr.addr       = free_slot_ff;
                     wr.rec        = rec_ff;
                     res_in.status = kst_pkg::ST_DONE;
                     res_in.used   = kst_pkg::IDX_W'(free_slot_ff);
                  end else if (scan_free) begin
                     wr.en         = 1'b1;
                     wr.addr       = cmp_ff;
                     wr.rec        = rec_ff;
                     res_in.status = kst_pkg::ST_DONE;
                     res_in.used   = kst_pkg::IDX_W'(cmp_ff);
                  end else begin
                     res_in.status = kst_pkg::ST_FULL;
                  end
               end else if (!free_seen_ff && scan_free) begin
                  free_seen_in = 1'b1;
                  free_slot_in = cmp_ff;
               end
            end
         end
         kst_pkg::S_FIN: begin
            res_load = out_free;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kst_pkg::S_IDLE;
         pend_ff      <= 1'b0;
         free_seen_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         free_seen_ff <= free_seen_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff  <= req_op;
         idx_ff <= req_idx;
         rec_ff <= req_rec;
      end
      scan_ff      <= scan_in;
      cmp_ff       <= cmp_in;
      free_slot_ff <= free_slot_in;
      res_ff       <= res_in;
   end

endmodule

`default_nettype wire

@@ rtl/core/kst_chk.sv @@
// Port-level checker for the keyed slot table upsert unit, with its bind.
// Depends on kst_pkg and keyed_slot_table_upsert_unit.
`default_nettype none

module kst_chk (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic [1:0]         req_opcode,
   input wire logic [6:0]         req_slot_index,
   input wire logic signed [31:0] req_profile_key,
   input wire logic [31:0]        req_rating_a_bits,
   input wire logic [31:0]        req_rating_b_bits,
   input wire logic [31:0]        req_record_flags,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [1:0]         rsp_status,
   input wire logic [6:0]         rsp_used_slot,
   input wire logic signed [31:0] rsp_out_key,
   input wire logic [31:0]        rsp_out_rating_a,
   input wire logic [31:0]        rsp_out_rating_b,
   input wire logic [31:0]        rsp_out_flags
);

   // busy after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous request in work");

   // only a successful read returns record data
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != kst_pkg::ST_DONE |->
         rsp_out_key == 0 && rsp_out_rating_a == 0 &&
         rsp_out_rating_b == 0 && rsp_out_flags == 0)
      else $error("record data on a response that is not a done read");

   // full and out-of-range responses name no slot
   a_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == kst_pkg::ST_FULL ||
                    rsp_status == kst_pkg::ST_RANGE) |-> rsp_used_slot == 0)
      else $error("slot reported on full or out-of-range response");

   // returned records are live
   a_read_live: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_flags != 0 |->
         rsp_out_flags[0] && rsp_out_key > 0)
      else $error("read returned a record that is not live");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_used_slot) && $stable(rsp_out_key) &&
         $stable(rsp_out_flags))
      else $error("response changed while stalled");

endmodule

bind keyed_slot_table_upsert_unit kst_chk u_kst_chk (.*);

`default_nettype wire
